// ----- src/ttb_pkg.sv -----
`timescale 1ns / 1ps
package ttb_pkg;

	localparam int WORD_W = 32;
	localparam int MUL_W  = 33;
	localparam int ACC_W  = 66;
	localparam int MAG_W  = 64;
	localparam int IN_W   = 256;
	localparam int OUT_W  = 192;

	localparam logic [WORD_W-1:0] SCALE_MIN = 32'h4000_0000;
	localparam logic [MAG_W-1:0]  SQRT_TOP  = 64'h4000_0000_0000_0000;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic signed [MUL_W-1:0]  mop_t;
	typedef logic signed [ACC_W-1:0]  acc_t;

	// last declared field (pos_x) in the lowest bits of the packed vector
	typedef struct packed {
		word_t norm_z;
		word_t norm_y;
		word_t norm_x;
		word_t tex_v;
		word_t tex_u;
		word_t pos_z;
		word_t pos_y;
		word_t pos_x;
	} vertex_t;

	typedef enum logic [1:0] {
		SLOT_V0 = 2'd0,
		SLOT_V1 = 2'd1,
		SLOT_V2 = 2'd2
	} slot_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_PREP,
		ST_DET,
		ST_NT,
		ST_TDIV,
		ST_NB,
		ST_BDIV,
		ST_DOT,
		ST_G,
		ST_ABS,
		ST_SCALE,
		ST_SQ,
		ST_SQRT,
		ST_UDIV,
		ST_CR,
		ST_HAND,
		ST_EMIT
	} state_t;

	function automatic word_t sat32(acc_t v);
		word_t r;
		if ((&v[ACC_W-1:WORD_W-1]) || !(|v[ACC_W-1:WORD_W-1])) begin
			r = v[WORD_W-1:0];
		end else if (v[ACC_W-1]) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'sh7fff_ffff;
		end
		return r;
	endfunction

	function automatic word_t sat_sub(word_t a, word_t b);
		logic signed [WORD_W:0] d;
		word_t r;
		d = {a[WORD_W-1], a} - {b[WORD_W-1], b};
		if (d[WORD_W] == d[WORD_W-1]) begin
			r = d[WORD_W-1:0];
		end else if (d[WORD_W]) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'sh7fff_ffff;
		end
		return r;
	endfunction

	function automatic logic [MAG_W-1:0] mag64(acc_t v);
		acc_t n;
		n = v[ACC_W-1] ? -v : v;
		return n[MAG_W-1:0];
	endfunction

	function automatic acc_t ext_word(word_t w);
		return {{(ACC_W-WORD_W){w[WORD_W-1]}}, w};
	endfunction

	function automatic mop_t mop_word(word_t w);
		return {w[WORD_W-1], w};
	endfunction

	function automatic logic [1:0] next3(logic [1:0] i);
		return (i == 2'd2) ? 2'd0 : i + 2'd1;
	endfunction

	function automatic word_t pos_of(vertex_t v, logic [1:0] i);
		word_t r;
		case (i)
			2'd0: r = v.pos_x;
			2'd1: r = v.pos_y;
			default: r = v.pos_z;
		endcase
		return r;
	endfunction

	function automatic word_t norm_of(vertex_t v, logic [1:0] i);
		word_t r;
		case (i)
			2'd0: r = v.norm_x;
			2'd1: r = v.norm_y;
			default: r = v.norm_z;
		endcase
		return r;
	endfunction

endpackage

// ----- src/ttb_mul.sv -----
`timescale 1ns / 1ps
module ttb_mul
	import ttb_pkg::*;
(
	input  logic clk,
	input  mop_t a,
	input  mop_t b,
	output acc_t prod_s1
);

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

endmodule

// ----- src/ttb_div.sv -----
`timescale 1ns / 1ps
module ttb_div
	import ttb_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [MAG_W-1:0]  num_mag,
	input  logic [MAG_W-1:0]  den_mag,
	input  logic              neg,
	output logic              done,
	output word_t             quo
);

	localparam int DVD_W = MAG_W + FRAC_BITS;
	localparam int CNT_W = $clog2(DVD_W);

	logic [DVD_W-1:0]  dvd_q;
	logic [MAG_W-1:0]  rem_q;
	logic [MAG_W-1:0]  den_q;
	logic [WORD_W-1:0] quo_q;
	logic              ovf_q;
	logic              neg_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [MAG_W:0]    rem_sh;
	logic [MAG_W:0]    diff;
	logic              take;
	logic [MAG_W-1:0]  rem_next;
	logic [WORD_W-1:0] lim;
	logic [WORD_W-1:0] mq;

	// one quotient bit per cycle while busy, restoring
	always_comb begin
		rem_sh   = {rem_q, dvd_q[DVD_W-1]};
		diff     = rem_sh - {1'b0, den_q};
		take     = !diff[MAG_W];
		rem_next = take ? diff[MAG_W-1:0] : rem_sh[MAG_W-1:0];
		lim      = neg_q ? 32'h8000_0000 : 32'h7fff_ffff;
		mq       = (ovf_q || (quo_q > lim)) ? lim : quo_q;
		quo      = neg_q ? -mq : mq;
		done     = done_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {num_mag, {FRAC_BITS{1'b0}}};
			rem_q <= '0;
			den_q <= den_mag;
			quo_q <= '0;
			ovf_q <= 1'b0;
			neg_q <= neg;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q <= rem_next;
			quo_q <= {quo_q[WORD_W-2:0], take};
			ovf_q <= ovf_q | quo_q[WORD_W-1];
		end
	end

endmodule

// ----- src/ttb_sqrt.sv -----
`timescale 1ns / 1ps
module ttb_sqrt
	import ttb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [MAG_W-1:0]  rad,
	output logic              done,
	output logic [WORD_W-1:0] root
);

	logic [MAG_W-1:0] x_q;
	logic [MAG_W-1:0] res_q;
	logic [MAG_W-1:0] bit_q;
	logic             busy_q;
	logic             done_q;
	logic [MAG_W-1:0] sum;
	logic             take;

	always_comb begin
		sum  = res_q + bit_q;
		take = x_q >= sum;
		done = done_q;
		root = res_q[WORD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// two radicand bits per cycle while busy
	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= rad;
			res_q <= '0;
			bit_q <= SQRT_TOP;
		end else if (busy_q) begin
			if (take) begin
				x_q   <= x_q - sum;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

// ----- src/triangle_tangent_basis.sv -----
`timescale 1ns / 1ps
// first and second vertex of a triangle: stored, no result
// third vertex: starts the triangle work, which emits one word per vertex; normalize shifts
// per vertex are 0..30, and a word waits while the output register stays full; a vertex with a
// zero tangent skips its root and divisions, so a zero determinant skips every division;
// each of the 15 divisions holds its step until the divider is done, the root likewise
// one item at a time; arst_n clears sequencer, vertex slot and output valid, not held vertices
module triangle_tangent_basis
	import ttb_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y, bitangent_z
	output logic [OUT_W-1:0] m_axis_tdata,
	output logic             m_axis_tlast,
	// degenerate
	output logic             m_axis_tuser
);

	state_t state_q, state_d;
	slot_t  slot_q;
	logic [2:0] tix_q, tix_d;
	logic [1:0] c_q, c_d;
	logic [1:0] k_q, k_d;

	vertex_t h0_q, h1_q, h2_q;
	word_t du1_q, dv1_q, du2_q, dv2_q;
	word_t e1_q [3];
	word_t e2_q [3];
	acc_t  det_q;
	logic  det_zero_q;
	logic  ok_q;
	word_t tan_q [3];
	word_t bit_q [3];
	word_t d_q;
	word_t g_q [3];
	logic [WORD_W-1:0] v_q [3];
	logic [WORD_W-1:0] len_q;
	word_t t_q [3];
	word_t cr_q [3];
	acc_t  acc_q;

	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;
	logic              out_last_q;
	logic              out_degen_q;

	logic [2:0] nterm;
	logic       mac, acc_en, wb, sub, preshift;
	logic [1:0] ti, ia, ib;
	vertex_t    nv;
	mop_t       mul_a, mul_b;
	acc_t       prod_s1;
	acc_t       addend;
	logic       in_take, out_load, div_start, sqrt_start;
	logic [MAG_W-1:0] div_num, div_den;
	logic       div_neg, div_done, sqrt_done;
	word_t      div_quo;
	logic [WORD_W-1:0] sqrt_root;
	logic [WORD_W-1:0] m01, vmax;

	ttb_mul u_mul (
		.clk     (clk),
		.a       (mul_a),
		.b       (mul_b),
		.prod_s1 (prod_s1)
	);

	ttb_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.num_mag (div_num),
		.den_mag (div_den),
		.neg     (div_neg),
		.done    (div_done),
		.quo     (div_quo)
	);

	ttb_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.rad    (acc_q[MAG_W-1:0]),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	// operand selection for the multiply-accumulate steps
	always_comb begin
		unique case (state_q)
			ST_DET, ST_NT, ST_NB, ST_CR: nterm = 3'd2;
			ST_DOT, ST_SQ, ST_HAND:      nterm = 3'd3;
			ST_G:                        nterm = 3'd1;
			default:                     nterm = 3'd0;
		endcase
		mac      = nterm != 3'd0;
		acc_en   = mac && (tix_q != 3'd0) && (tix_q <= nterm);
		wb       = mac && (tix_q == nterm + 3'd1);
		ti       = (tix_q < 3'd3) ? tix_q[1:0] : 2'd0;
		ia       = next3(c_q);
		ib       = next3(ia);
		sub      = (state_q == ST_G) ||
			(((state_q == ST_DET) || (state_q == ST_NT) || (state_q == ST_NB) ||
			(state_q == ST_CR)) && (tix_q == 3'd2));
		preshift = (state_q == ST_DOT) || (state_q == ST_G);
		addend   = preshift ? (prod_s1 >>> FRAC_BITS) : prod_s1;

		case (k_q)
			2'd0:    nv = h0_q;
			2'd1:    nv = h1_q;
			default: nv = h2_q;
		endcase

		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_DET: begin
				mul_a = mop_word(ti == 2'd0 ? du1_q : dv1_q);
				mul_b = mop_word(ti == 2'd0 ? dv2_q : du2_q);
			end
			ST_NT: begin
				mul_a = mop_word(ti == 2'd0 ? e1_q[c_q] : e2_q[c_q]);
				mul_b = mop_word(ti == 2'd0 ? dv2_q : dv1_q);
			end
			ST_NB: begin
				mul_a = mop_word(ti == 2'd0 ? e2_q[c_q] : e1_q[c_q]);
				mul_b = mop_word(ti == 2'd0 ? du1_q : du2_q);
			end
			ST_DOT: begin
				mul_a = mop_word(norm_of(nv, ti));
				mul_b = mop_word(tan_q[ti]);
			end
			ST_G: begin
				mul_a = mop_word(norm_of(nv, c_q));
				mul_b = mop_word(d_q);
			end
			ST_SQ: begin
				mul_a = {1'b0, v_q[ti]};
				mul_b = {1'b0, v_q[ti]};
			end
			ST_CR: begin
				mul_a = mop_word(norm_of(nv, ti == 2'd0 ? ia : ib));
				mul_b = mop_word(ti == 2'd0 ? t_q[ib] : t_q[ia]);
			end
			ST_HAND: begin
				mul_a = mop_word(cr_q[ti]);
				mul_b = mop_word(bit_q[ti]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase

		if (state_q == ST_UDIV) begin
			div_num = {{(MAG_W-WORD_W){1'b0}}, v_q[c_q]};
			div_den = {{(MAG_W-WORD_W){1'b0}}, len_q};
			div_neg = g_q[c_q][WORD_W-1];
		end else begin
			div_num = mag64(acc_q);
			div_den = mag64(det_q);
			div_neg = acc_q[ACC_W-1] ^ det_q[ACC_W-1];
		end

		m01  = (v_q[0] > v_q[1]) ? v_q[0] : v_q[1];
		vmax = (m01 > v_q[2]) ? m01 : v_q[2];
	end

	// sequencer
	always_comb begin
		state_d    = state_q;
		tix_d      = tix_q;
		c_d        = c_q;
		k_d        = k_q;
		div_start  = 1'b0;
		sqrt_start = 1'b0;
		out_load   = 1'b0;
		in_take    = s_axis_tvalid && (state_q == ST_IDLE);
		if (mac) begin
			tix_d = wb ? 3'd0 : tix_q + 3'd1;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (in_take && (slot_q == SLOT_V2)) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: state_d = ST_DET;
			ST_DET: begin
				if (wb) begin
					state_d = (acc_q == '0) ? ST_DOT : ST_NT;
					c_d     = 2'd0;
					k_d     = 2'd0;
				end
			end
			ST_NT: begin
				if (wb) begin
					state_d = ST_TDIV;
				end
			end
			ST_TDIV: begin
				if (tix_q == 3'd0) begin
					div_start = 1'b1;
					tix_d     = 3'd1;
				end else if (div_done) begin
					tix_d   = 3'd0;
					state_d = ST_NB;
				end
			end
			ST_NB: begin
				if (wb) begin
					state_d = ST_BDIV;
				end
			end
			ST_BDIV: begin
				if (tix_q == 3'd0) begin
					div_start = 1'b1;
					tix_d     = 3'd1;
				end else if (div_done) begin
					tix_d = 3'd0;
					if (c_q == 2'd2) begin
						state_d = ST_DOT;
						c_d     = 2'd0;
					end else begin
						state_d = ST_NT;
						c_d     = c_q + 2'd1;
					end
				end
			end
			ST_DOT: begin
				if (wb) begin
					state_d = ST_G;
					c_d     = 2'd0;
				end
			end
			ST_G: begin
				if (wb) begin
					if (c_q == 2'd2) begin
						state_d = ST_ABS;
					end else begin
						c_d = c_q + 2'd1;
					end
				end
			end
			ST_ABS: state_d = ST_SCALE;
			ST_SCALE: begin
				if (vmax == '0) begin
					state_d = ST_EMIT;
				end else if (vmax >= SCALE_MIN) begin
					state_d = ST_SQ;
				end
			end
			ST_SQ: begin
				if (wb) begin
					state_d = ST_SQRT;
				end
			end
			ST_SQRT: begin
				if (tix_q == 3'd0) begin
					sqrt_start = 1'b1;
					tix_d      = 3'd1;
				end else if (sqrt_done) begin
					tix_d   = 3'd0;
					c_d     = 2'd0;
					state_d = ST_UDIV;
				end
			end
			ST_UDIV: begin
				if (tix_q == 3'd0) begin
					div_start = 1'b1;
					tix_d     = 3'd1;
				end else if (div_done) begin
					tix_d = 3'd0;
					if (c_q == 2'd2) begin
						state_d = ST_CR;
						c_d     = 2'd0;
					end else begin
						c_d = c_q + 2'd1;
					end
				end
			end
			ST_CR: begin
				if (wb) begin
					if (c_q == 2'd2) begin
						state_d = ST_HAND;
					end else begin
						c_d = c_q + 2'd1;
					end
				end
			end
			ST_HAND: begin
				if (wb) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					if (k_q == 2'd2) begin
						state_d = ST_IDLE;
					end else begin
						k_d     = k_q + 2'd1;
						c_d     = 2'd0;
						state_d = ST_DOT;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slot_q      <= SLOT_V0;
			tix_q       <= '0;
			c_q         <= '0;
			k_q         <= '0;
			det_zero_q  <= 1'b0;
			ok_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			tix_q   <= tix_d;
			c_q     <= c_d;
			k_q     <= k_d;
			if (in_take) begin
				unique case (slot_q)
					SLOT_V1: slot_q <= SLOT_V2;
					SLOT_V2: slot_q <= SLOT_V0;
					default: slot_q <= SLOT_V1;
				endcase
			end
			if ((state_q == ST_DET) && wb) begin
				det_zero_q <= acc_q == '0;
			end
			if (state_q == ST_SCALE) begin
				ok_q <= vmax != '0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			unique case (slot_q)
				SLOT_V1: h1_q <= vertex_t'(s_axis_tdata);
				SLOT_V2: h2_q <= vertex_t'(s_axis_tdata);
				default: h0_q <= vertex_t'(s_axis_tdata);
			endcase
		end

		if (mac && (tix_q == 3'd0)) begin
			acc_q <= (state_q == ST_G) ? ext_word(tan_q[c_q]) : '0;
		end else if (acc_en) begin
			acc_q <= sub ? acc_q - addend : acc_q + addend;
		end

		case (state_q)
			ST_PREP: begin
				du1_q <= sat_sub(h1_q.tex_u, h0_q.tex_u);
				dv1_q <= sat_sub(h1_q.tex_v, h0_q.tex_v);
				du2_q <= sat_sub(h2_q.tex_u, h0_q.tex_u);
				dv2_q <= sat_sub(h2_q.tex_v, h0_q.tex_v);
				for (int i = 0; i < 3; i++) begin
					e1_q[i] <= sat_sub(pos_of(h1_q, 2'(i)), pos_of(h0_q, 2'(i)));
					e2_q[i] <= sat_sub(pos_of(h2_q, 2'(i)), pos_of(h0_q, 2'(i)));
				end
			end
			ST_DET: begin
				if (wb) begin
					det_q <= acc_q;
					if (acc_q == '0) begin
						for (int i = 0; i < 3; i++) begin
							tan_q[i] <= '0;
							bit_q[i] <= '0;
						end
					end
				end
			end
			ST_TDIV: begin
				if ((tix_q != 3'd0) && div_done) begin
					tan_q[c_q] <= div_quo;
				end
			end
			ST_BDIV: begin
				if ((tix_q != 3'd0) && div_done) begin
					bit_q[c_q] <= div_quo;
				end
			end
			ST_DOT: begin
				if (wb) begin
					d_q <= sat32(acc_q);
				end
			end
			ST_G: begin
				if (wb) begin
					g_q[c_q] <= sat32(acc_q);
				end
			end
			ST_ABS: begin
				for (int i = 0; i < 3; i++) begin
					v_q[i] <= g_q[i][WORD_W-1] ? -g_q[i] : g_q[i];
				end
			end
			ST_SCALE: begin
				// bring the largest component up to [2^30, 2^31]
				if (vmax == '0) begin
					for (int i = 0; i < 3; i++) begin
						t_q[i] <= '0;
					end
				end else if (vmax < SCALE_MIN) begin
					for (int i = 0; i < 3; i++) begin
						v_q[i] <= {v_q[i][WORD_W-2:0], 1'b0};
					end
				end
			end
			ST_SQRT: begin
				if ((tix_q != 3'd0) && sqrt_done) begin
					len_q <= sqrt_root;
				end
			end
			ST_UDIV: begin
				if ((tix_q != 3'd0) && div_done) begin
					t_q[c_q] <= div_quo;
				end
			end
			ST_CR: begin
				if (wb) begin
					cr_q[c_q] <= sat32(acc_q >>> FRAC_BITS);
				end
			end
			ST_HAND: begin
				// flip when cross(n,t) points away from the bitangent
				if (wb && acc_q[ACC_W-1]) begin
					for (int i = 0; i < 3; i++) begin
						t_q[i] <= -t_q[i];
					end
				end
			end
			default: begin
			end
		endcase

		if (out_load) begin
			out_data_q  <= {bit_q[2], bit_q[1], bit_q[0], t_q[2], t_q[1], t_q[0]};
			out_last_q  <= k_q == 2'd2;
			out_degen_q <= det_zero_q || !ok_q;
		end
	end

	assign s_axis_tready = state_q == ST_IDLE;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_degen_q;

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> ((state_q == ST_TDIV) || (state_q == ST_BDIV) || (state_q == ST_UDIV)))
		else $error("divider finished outside a division step");

	a_sqrt_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_done |-> (state_q == ST_SQRT))
		else $error("square root finished outside its step");

	a_third_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && (slot_q == SLOT_V2)) |=> (state_q == ST_PREP))
		else $error("third vertex did not start triangle work");

	a_zero_det_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && det_zero_q) |=> (m_axis_tuser && (m_axis_tdata == '0)))
		else $error("zero determinant word is not all zero and flagged");

endmodule
